FILE: design/frb_pkg.sv
// Shared types and constants for the frame brighten, rotate and flip block.
// Used by every module of the block but frb_ram; depends on nothing.
package frb_pkg;

    // Widths fixed by the configuration registers and the pixel format.
    localparam int DIM_W  = 9;               // frame width and height
    localparam int LC_W   = 2 * DIM_W;       // pixel count within a frame
    localparam int PIX_W  = 8;
    localparam int MODE_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [PIX_W-1:0] STEP_LEVEL = 8'd30;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_BRIGHTEN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DARKEN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR_V = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd3;

    // Work passed from the front to the back.
    typedef enum logic [1:0] {
        OP_POINT,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel;
        logic [LC_W-1:0]  addr;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             last;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADDR,
        BK_READ
    } bk_state_t;

endpackage

FILE: design/frb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/frb_front.sv
// Front of the block: configuration registers, request classification and frame counters.
// Depends on frb_pkg; feeds frb_queue.
module frb_front
    import frb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [PIX_W-1:0]      s_pixel_in,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd,
    output logic [DIM_W-1:0]      width_eff
);

    logic [MODE_W-1:0] mode_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [PIX_W-1:0]  level_reg;
    logic [LC_W-1:0]   total_reg;
    logic              settle_reg;
    logic [LC_W-1:0]   lc_reg, lc_next;
    logic [DIM_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic              drained_reg, drained_next;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic              accept;

    always_comb begin
        w_eff = (width_reg == '0) ? DIM_W'(1) : width_reg;
        if (int'(width_reg) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;
        if (int'(height_reg) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    assign width_eff = w_eff;
    // Hold off requests in the cycle after a write or a reset so the frame size
    // product settles.
    assign s_ready   = !q_full && !settle_reg;
    assign accept    = s_valid && s_ready;

    always_comb begin
        logic [LC_W-1:0]  lc_inc;
        logic [DIM_W-1:0] col_inc, row_inc, orows, ocols;
        logic [PIX_W:0]   sum;

        lc_inc  = lc_reg + 1'b1;
        col_inc = col_reg + 1'b1;
        row_inc = row_reg + 1'b1;
        sum     = {1'b0, s_pixel_in} + {1'b0, STEP_LEVEL};
        orows   = (mode_reg == MODE_ROTATE) ? w_eff : h_eff;
        ocols   = (mode_reg == MODE_ROTATE) ? h_eff : w_eff;

        lc_next      = lc_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        drained_next = drained_reg;
        q_push       = 1'b0;
        q_cmd        = '{op: OP_POINT, pixel: s_pixel_in, addr: lc_reg,
                         row: row_reg, col: col_reg, last: 1'b0};

        if (accept) begin
            case (mode_reg)
                MODE_BRIGHTEN, MODE_DARKEN: begin
                    if (!s_kind) begin
                        q_push = 1'b1;
                        if (mode_reg == MODE_BRIGHTEN) begin
                            q_cmd.pixel = (sum > {1'b0, level_reg}) ? level_reg
                                                                    : sum[PIX_W-1:0];
                        end else begin
                            q_cmd.pixel = (s_pixel_in < STEP_LEVEL) ? '0
                                                                    : s_pixel_in - STEP_LEVEL;
                        end
                        if (lc_inc >= total_reg) begin
                            q_cmd.last = 1'b1;
                            lc_next    = '0;
                        end else begin
                            lc_next    = lc_inc;
                        end
                    end
                end
                MODE_ROTATE, MODE_MIRROR_H, MODE_MIRROR_V: begin
                    if (!s_kind) begin
                        if (drained_reg) begin
                            // A pixel after the drain opens a new frame at entry zero.
                            q_push       = 1'b1;
                            q_cmd.op     = OP_WRITE;
                            q_cmd.addr   = '0;
                            lc_next      = LC_W'(1);
                            row_next     = '0;
                            col_next     = '0;
                            drained_next = 1'b0;
                        end else if (lc_reg < total_reg) begin
                            q_push     = 1'b1;
                            q_cmd.op   = OP_WRITE;
                            lc_next    = lc_inc;
                        end
                    end else if (!drained_reg && lc_reg >= total_reg) begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_READ;
                        if (mode_reg == MODE_ROTATE) begin
                            q_cmd.row = h_eff - 1'b1 - col_reg;
                            q_cmd.col = row_reg;
                        end else if (mode_reg == MODE_MIRROR_H) begin
                            q_cmd.row = row_reg;
                            q_cmd.col = w_eff - 1'b1 - col_reg;
                        end else begin
                            q_cmd.row = h_eff - 1'b1 - row_reg;
                            q_cmd.col = col_reg;
                        end
                        if (col_inc >= ocols) begin
                            col_next = '0;
                            row_next = row_inc;
                            if (row_inc >= orows) begin
                                drained_next = 1'b1;
                                q_cmd.last   = 1'b1;
                            end
                        end else begin
                            col_next = col_inc;
                        end
                    end
                end
                default: begin
                    // Unused modes swallow every request.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= LC_W'(w_eff * h_eff);
        if (!aresetn) begin
            mode_reg    <= MODE_BRIGHTEN;
            width_reg   <= DIM_W'(256);
            height_reg  <= DIM_W'(256);
            level_reg   <= 8'd255;
            settle_reg  <= 1'b1;
            lc_reg      <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            drained_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_LEVEL:  level_reg  <= cfg_data[PIX_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
            settle_reg  <= 1'b1;
            lc_reg      <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            drained_reg <= 1'b0;
        end else begin
            settle_reg  <= 1'b0;
            lc_reg      <= lc_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            drained_reg <= drained_next;
        end
    end

endmodule

FILE: design/frb_queue.sv
// Short first-in first-out queue of commands between the front and the back.
// Depends on frb_pkg for the command type.
module frb_queue
    import frb_pkg::*;
#(
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH)
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

FILE: design/frb_back.sv
// Back of the block: carries out queued commands against the frame store and drives results.
// Depends on frb_pkg and frb_ram.
module frb_back
    import frb_pkg::*;
#(
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             head,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic [DIM_W-1:0] width_eff,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_last
);

    bk_state_t        state_reg, state_next;
    logic [DIM_W-1:0] row_reg, col_reg;
    logic             rd_last_reg;
    logic [LC_W-1:0]  prod_reg;
    logic             m_valid_reg;
    logic [PIX_W-1:0] pixel_reg;
    logic             last_reg;

    logic             out_free, load_out, latch_read;
    logic [PIX_W-1:0] load_pixel;
    logic             load_last;
    logic             ram_we, ram_re;
    logic [PIX_W-1:0] ram_rdata;
    logic [LC_W-1:0]  rd_addr;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_addr  = prod_reg + LC_W'(col_reg);

    frb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(head.addr)),
        .wr_data (head.pixel),
        .rd_en   (ram_re),
        .rd_addr (AW'(rd_addr)),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        load_out   = 1'b0;
        latch_read = 1'b0;
        load_pixel = head.pixel;
        load_last  = head.last;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    case (head.op)
                        OP_POINT: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                load_out = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            q_pop  = 1'b1;
                            ram_we = 1'b1;
                        end
                        OP_READ: begin
                            q_pop      = 1'b1;
                            latch_read = 1'b1;
                            state_next = BK_MUL;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            BK_MUL:  state_next = BK_ADDR;
            BK_ADDR: begin
                ram_re     = 1'b1;
                state_next = BK_READ;
            end
            BK_READ: begin
                // The read data holds until it has moved into the output register.
                load_pixel = ram_rdata;
                load_last  = rd_last_reg;
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (latch_read) begin
            row_reg     <= head.row;
            col_reg     <= head.col;
            rd_last_reg <= head.last;
        end
        if (state_reg == BK_MUL) begin
            prod_reg <= LC_W'(row_reg * width_eff);
        end
        if (load_out) begin
            pixel_reg <= load_pixel;
            last_reg  <= load_last;
        end
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = pixel_reg;
    assign m_last      = last_reg;

endmodule

FILE: design/frame_brighten_rotate_flip.sv
// Top level of the frame brighten, rotate and flip block.
// Depends on frb_pkg, frb_front, frb_queue, frb_back and frb_ram.
//
// Usage. Requests arrive on the s_ channel: s_kind 0 carries a grey pixel of the
// input frame in row order, s_kind 1 asks for the next output pixel. Results leave
// on the m_ channel with m_last set on the final pixel of the output frame.
// In brighten and darken modes each pixel request gives one result, and requests are
// taken one per cycle while the command queue has room. In the rotate and mirror modes
// pixel requests are written into the frame store at one per cycle while the queue has
// room, and each pull gives one pixel; the back unit takes each pull through queue pop,
// row times width product, store address and store read before it takes the next command.
// Pulls before the frame is complete or after it has drained give no result.
// The configuration port takes one write per cycle, restarts the frame, and holds
// s_ready low for the cycle after the write while the frame size settles.
// Reset is synchronous and active low; it restores the default registers and an
// empty frame, and s_ready stays low during reset and for the first cycle after it.
// The frame store is not cleared, so no start-up pass is needed.
// When the receiver stalls, the result waits in the output register; the command
// queue keeps taking requests until it is full, and then s_ready falls.
module frame_brighten_rotate_flip
    import frb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [PIX_W-1:0]      s_pixel_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_pixel_out,
    output logic                  m_last
);

    // The frame store holds one full frame of the largest size.
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int QUEUE_DEPTH = 4;

    cmd_t             push_cmd, head;
    logic             q_push, q_pop, q_empty, q_full;
    logic [DIM_W-1:0] width_eff;

    // The front classifies each request and keeps the frame counters.
    frb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_pixel_in (s_pixel_in),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .width_eff  (width_eff)
    );

    // The queue lets the front keep accepting while the back waits on the receiver.
    frb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The back performs store writes and reads and owns the output register.
    frb_back #(
        .DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .width_eff   (width_eff),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_last      (m_last)
    );

endmodule

FILE: design/frb_checker.sv
// Port-level checks for frame_brighten_rotate_flip, attached by a bind statement.
// Depends on frb_pkg and the top level.
module frb_checker
    import frb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_we,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [PIX_W-1:0]      m_pixel_out,
    input logic                  m_last
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_last))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // After a register write no request is taken until the frame size has settled.
    a_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("request taken straight after a register write");

endmodule

bind frame_brighten_rotate_flip frb_checker u_frb_checker (.*);
